// ===== rtl/http_cache_max_age_parser_top_macros.svh =====
// Assertion macros for the cache max-age parser.
// Used by http_cache_max_age_parser_top; expects clk and rst_n in scope.
`ifndef HTTP_CACHE_MAX_AGE_PARSER_TOP_MACROS_SVH
`define HTTP_CACHE_MAX_AGE_PARSER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HCMA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HCMA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hcma_pkg.sv =====
// Shared types, constants and parse functions for the cache max-age parser.
// No dependencies; used by hcma_parser and http_cache_max_age_parser_top.
package hcma_pkg;

  localparam int HEADER_BYTES_MAX = 4096;
  // count saturates at HEADER_BYTES_MAX + 1
  localparam int BYTE_CNT_W = $clog2(HEADER_BYTES_MAX + 2);
  localparam int AGE_W = 16;
  localparam int MS_W = 26;
  localparam int MS_PER_S = 1000;
  localparam logic [AGE_W-1:0] CAP_RESET = 16'd20;

  typedef logic [7:0] hbyte_t;

  localparam hbyte_t CH_TAB    = 8'h09;
  localparam hbyte_t CH_LF     = 8'h0A;
  localparam hbyte_t CH_CR     = 8'h0D;
  localparam hbyte_t CH_SP     = 8'h20;
  localparam hbyte_t CH_QUOTE  = 8'h22;
  localparam hbyte_t CH_COMMA  = 8'h2C;
  localparam hbyte_t CH_ZERO   = 8'h30;
  localparam hbyte_t CH_NINE   = 8'h39;
  localparam hbyte_t CH_COLON  = 8'h3A;
  localparam hbyte_t CH_EQ     = 8'h3D;
  localparam hbyte_t CH_UP_A   = 8'h41;
  localparam hbyte_t CH_UP_Z   = 8'h5A;
  localparam hbyte_t CH_BSLASH = 8'h5C;
  localparam hbyte_t CASE_DELTA = 8'h20;

  typedef enum logic [1:0] {LP_NAME, LP_CC, LP_OTHER} line_phase_t;
  typedef enum logic [2:0] {DP_SKIP, DP_NAME, DP_PRE, DP_POST, DP_DIGITS, DP_IGNORE} dir_phase_t;

  // Words 0..2 are header names, 3..5 directive names; text is right-justified.
  localparam int WORD_CNT = 6;
  localparam int WORD_CHARS = 13;
  localparam logic [WORD_CHARS*8-1:0] WORD_TEXT [WORD_CNT] = '{
    "cache-control", "age", "vary", "max-age", "no-store", "no-cache"
  };
  localparam logic [3:0] WORD_LEN [WORD_CNT] = '{4'd13, 4'd3, 4'd4, 4'd7, 4'd8, 4'd8};
  localparam logic [2:0] NAME_BASE = 3'd0;
  localparam logic [2:0] DIR_BASE = 3'd3;
  localparam logic [2:0] CAND_ALL = 3'b111;
  localparam logic [3:0] POS_MAX = 4'd15;

  typedef struct packed {
    logic                  rejected;
    logic [BYTE_CNT_W-1:0] bytes_seen;
    line_phase_t           line_phase;
    logic [3:0]            name_position;
    logic [2:0]            name_candidates;
    dir_phase_t            directive_phase;
    logic [3:0]            directive_position;
    logic [2:0]            directive_candidates;
    logic                  quote_open;
    logic                  escape_pending;
    logic                  trailing_blank;
    logic                  max_age_seen;
    logic [AGE_W-1:0]      age_value;
  } prs_state_t;

  localparam prs_state_t PRS_RESET = '{
    rejected: 1'b0,
    bytes_seen: '0,
    line_phase: LP_NAME,
    name_position: 4'd0,
    name_candidates: CAND_ALL,
    directive_phase: DP_SKIP,
    directive_position: 4'd0,
    directive_candidates: CAND_ALL,
    quote_open: 1'b0,
    escape_pending: 1'b0,
    trailing_blank: 1'b0,
    max_age_seen: 1'b0,
    age_value: '0
  };

  function automatic hbyte_t to_lower(hbyte_t b);
    return (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_DELTA : b;
  endfunction

  function automatic hbyte_t word_char(logic [2:0] w, logic [3:0] pos);
    logic [3:0] sh;
    sh = WORD_LEN[w] - 4'd1 - pos;
    return WORD_TEXT[w][{sh, 3'b000} +: 8];
  endfunction

  // Keep the candidates whose next character matches b.
  function automatic logic [2:0] advance(logic [2:0] live, logic [3:0] pos, hbyte_t b,
                                         logic [2:0] base);
    logic [2:0] res;
    logic [2:0] w;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      w = base + 3'(k);
      if (live[k] && pos < WORD_LEN[w] && word_char(w, pos) == to_lower(b)) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [2:0] complete(logic [2:0] live, logic [3:0] pos,
                                          logic [2:0] base);
    logic [2:0] res;
    logic [2:0] w;
    res = '0;
    for (int k = 0; k < 3; k++) begin
      w = base + 3'(k);
      if (live[k] && pos == WORD_LEN[w]) begin
        res[k] = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic is_trim(hbyte_t b);
    return b == CH_SP || b == CH_TAB || b == CH_CR;
  endfunction

  function automatic void start_directive(inout prs_state_t s);
    s.directive_phase = DP_NAME;
    s.directive_position = 4'd0;
    s.directive_candidates = CAND_ALL;
    s.quote_open = 1'b0;
    s.escape_pending = 1'b0;
    s.trailing_blank = 1'b0;
  endfunction

  // Returns 1 when the finished directive name is max-age.
  function automatic logic settle_name(inout prs_state_t s);
    logic [2:0] m;
    m = complete(s.directive_candidates, s.directive_position, DIR_BASE);
    if (m[2:1] != 2'b00) begin
      s.rejected = 1'b1;
    end
    if (m[0]) begin
      if (s.max_age_seen) begin
        s.rejected = 1'b1;
      end
      s.max_age_seen = 1'b1;
    end
    return m[0];
  endfunction

  function automatic void take_digit(inout prs_state_t s, input hbyte_t b,
                                     input logic [AGE_W-1:0] cap);
    logic [AGE_W+3:0] v;
    v = ((AGE_W+4)'(s.age_value) << 3) + ((AGE_W+4)'(s.age_value) << 1)
        + (AGE_W+4)'(b[3:0]);
    if (v > (AGE_W+4)'(cap)) begin
      s.age_value = cap;
    end else begin
      s.age_value = v[AGE_W-1:0];
    end
  endfunction

  function automatic void fail_directive(inout prs_state_t s);
    s.rejected = 1'b1;
    s.directive_phase = DP_IGNORE;
  endfunction

  function automatic void feed(inout prs_state_t s, input hbyte_t b,
                               input logic [AGE_W-1:0] cap);
    logic blank;
    logic digit;
    logic ma;
    blank = (b == CH_SP || b == CH_TAB);
    digit = (b >= CH_ZERO && b <= CH_NINE);
    case (s.directive_phase)
      DP_NAME: begin
        if (s.trailing_blank) begin
          if (!is_trim(b)) begin
            s.directive_phase = DP_IGNORE;
          end
        end else if (b == CH_EQ || blank) begin
          ma = settle_name(s);
          if (ma) begin
            s.directive_phase = (b == CH_EQ) ? DP_POST : DP_PRE;
          end else begin
            s.directive_phase = DP_IGNORE;
          end
        end else if (b == CH_CR) begin
          if (complete(s.directive_candidates, s.directive_position, DIR_BASE) != 3'b000) begin
            s.trailing_blank = 1'b1;
          end else begin
            s.directive_phase = DP_IGNORE;
          end
        end else begin
          s.directive_candidates = advance(s.directive_candidates, s.directive_position, b,
                                           DIR_BASE);
          if (s.directive_position < POS_MAX) begin
            s.directive_position = s.directive_position + 4'd1;
          end
          if (s.directive_candidates == 3'b000) begin
            s.directive_phase = DP_IGNORE;
          end
        end
      end
      DP_PRE: begin
        if (b == CH_EQ) begin
          s.directive_phase = DP_POST;
        end else if (!blank) begin
          fail_directive(s);
        end
      end
      DP_POST: begin
        if (digit) begin
          take_digit(s, b, cap);
          s.directive_phase = DP_DIGITS;
        end else if (!blank) begin
          fail_directive(s);
        end
      end
      DP_DIGITS: begin
        if (s.trailing_blank) begin
          if (!is_trim(b)) begin
            fail_directive(s);
          end
        end else if (digit) begin
          take_digit(s, b, cap);
        end else if (is_trim(b)) begin
          s.trailing_blank = 1'b1;
        end else begin
          fail_directive(s);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void end_directive(inout prs_state_t s);
    logic ma;
    if (s.directive_phase == DP_NAME) begin
      ma = settle_name(s);
      if (ma) begin
        s.rejected = 1'b1;
      end
    end else if (s.directive_phase == DP_PRE || s.directive_phase == DP_POST) begin
      s.rejected = 1'b1;
    end
    s.directive_phase = DP_SKIP;
    s.trailing_blank = 1'b0;
    s.quote_open = 1'b0;
    s.escape_pending = 1'b0;
  endfunction

  function automatic void value_byte(inout prs_state_t s, input hbyte_t b,
                                     input logic [AGE_W-1:0] cap);
    logic skip;
    skip = 1'b0;
    if (s.directive_phase == DP_SKIP) begin
      if (b == CH_SP || b == CH_TAB || b == CH_COMMA) begin
        skip = 1'b1;
      end else begin
        start_directive(s);
      end
    end
    if (!skip) begin
      if (s.escape_pending) begin
        s.escape_pending = 1'b0;
        feed(s, b, cap);
      end else if (s.quote_open && b == CH_BSLASH) begin
        s.escape_pending = 1'b1;
        feed(s, b, cap);
      end else if (b == CH_QUOTE) begin
        s.quote_open = ~s.quote_open;
        feed(s, b, cap);
      end else if (!s.quote_open && b == CH_COMMA) begin
        end_directive(s);
      end else begin
        feed(s, b, cap);
      end
    end
  endfunction

  function automatic void end_line(inout prs_state_t s);
    if (s.line_phase == LP_CC && s.directive_phase != DP_SKIP) begin
      if (s.quote_open || s.escape_pending) begin
        s.rejected = 1'b1;
      end
      end_directive(s);
    end
    s.line_phase = LP_NAME;
    s.name_position = 4'd0;
    s.name_candidates = CAND_ALL;
    s.directive_phase = DP_SKIP;
    s.trailing_blank = 1'b0;
    s.quote_open = 1'b0;
    s.escape_pending = 1'b0;
  endfunction

  function automatic void line_byte(inout prs_state_t s, input hbyte_t b,
                                    input logic [AGE_W-1:0] cap);
    logic [2:0] m;
    if (b == CH_LF) begin
      end_line(s);
    end else if (s.line_phase == LP_NAME) begin
      if (b == CH_COLON) begin
        m = complete(s.name_candidates, s.name_position, NAME_BASE);
        if (m[2:1] != 2'b00) begin
          // age or vary header: not cacheable
          s.rejected = 1'b1;
          s.line_phase = LP_OTHER;
        end else if (m[0]) begin
          s.line_phase = LP_CC;
          s.directive_phase = DP_SKIP;
        end else begin
          s.line_phase = LP_OTHER;
        end
      end else begin
        s.name_candidates = advance(s.name_candidates, s.name_position, b, NAME_BASE);
        if (s.name_position < POS_MAX) begin
          s.name_position = s.name_position + 4'd1;
        end
        if (s.name_candidates == 3'b000) begin
          s.line_phase = LP_OTHER;
        end
      end
    end else if (s.line_phase == LP_CC) begin
      value_byte(s, b, cap);
    end
  endfunction

endpackage

// ===== rtl/hcma_parser.sv =====
// Byte-at-a-time header parse state and its registered per-byte update.
// Depends on hcma_pkg for the state type and the parse functions.
module hcma_parser (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step_en,
  input  hcma_pkg::hbyte_t              hdr_byte,
  input  logic                          last,
  input  logic [hcma_pkg::AGE_W-1:0]    cap,
  output logic [hcma_pkg::AGE_W-1:0]    res_age
);

  hcma_pkg::prs_state_t st_r;
  hcma_pkg::prs_state_t st_nxt;

  always_comb begin
    st_nxt = st_r;
    res_age = '0;
    if (step_en) begin
      if (st_nxt.bytes_seen <= hcma_pkg::BYTE_CNT_W'(hcma_pkg::HEADER_BYTES_MAX)) begin
        st_nxt.bytes_seen = st_nxt.bytes_seen + 1'b1;
      end
      if (st_nxt.bytes_seen > hcma_pkg::BYTE_CNT_W'(hcma_pkg::HEADER_BYTES_MAX)) begin
        st_nxt.rejected = 1'b1;
      end
      hcma_pkg::line_byte(st_nxt, hdr_byte, cap);
      if (last) begin
        hcma_pkg::end_line(st_nxt);
        res_age = st_nxt.rejected ? '0 : st_nxt.age_value;
        // start over for the next header block
        st_nxt = hcma_pkg::PRS_RESET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hcma_pkg::PRS_RESET;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/http_cache_max_age_parser_top.sv =====
// Cache max-age parser top level: input register, parser, result pipeline.
// Depends on hcma_pkg, hcma_parser and http_cache_max_age_parser_top_macros.svh.
//
// Usage:
//   The in_ channel carries one header byte per word (in_tdata) with in_tlast
//   on the final byte of a response header block. One word on the out_
//   channel follows each in_tlast word: the cache lifetime in milliseconds,
//   0 when the block is not cacheable or malformed.
//   cfg_wr_en/cfg_wr_data set the max-age cap in seconds (reset 20); write it
//   only between blocks.
// Timing:
//   One byte per cycle sustained, except while a last byte waits for room in the
//   result stages. A taken non-last byte is parsed straight out of the input
//   register in the next cycle; a last byte's age passes fin_age_r, then the
//   multiply by 1000 into out_ms_r. The parse state update loop sets this rate.
// Reset and stall:
//   rst_n (synchronous) clears the parse state, empties the pipeline and
//   restores the cap. While out_tready is low, non-last bytes keep flowing;
//   a last byte waits in the input register only while both result stages
//   hold undelivered results.
module http_cache_max_age_parser_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] header_byte
  input  logic        in_tlast,     // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // [25:0] max_age_ms, [31:26] zero
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data   // max_age_cap_seconds
);

  `include "http_cache_max_age_parser_top_macros.svh"

  logic                           in_v_r;
  hcma_pkg::hbyte_t               in_byte_r;
  logic                           in_last_r;
  logic [hcma_pkg::AGE_W-1:0]     cap_r;
  logic                           fin_v_r;
  logic [hcma_pkg::AGE_W-1:0]     fin_age_r;
  logic                           out_v_r;
  logic [hcma_pkg::MS_W-1:0]      out_ms_r;

  logic                           out_free;
  logic                           fin_free;
  logic                           s0_go;
  logic [hcma_pkg::AGE_W-1:0]     res_age;
  logic [hcma_pkg::MS_W-1:0]      out_ms_nxt;

  assign out_free = !out_v_r || out_tready;
  assign fin_free = !fin_v_r || out_free;
  // only a last byte needs room downstream
  assign s0_go = in_v_r && (!in_last_r || fin_free);
  assign in_tready = !in_v_r || s0_go;

  hcma_parser u_parser (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (s0_go),
    .hdr_byte (in_byte_r),
    .last     (in_last_r),
    .cap      (cap_r),
    .res_age  (res_age)
  );

  assign out_ms_nxt = hcma_pkg::MS_W'(fin_age_r) * hcma_pkg::MS_W'(hcma_pkg::MS_PER_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      out_v_r <= 1'b0;
      cap_r   <= hcma_pkg::CAP_RESET;
    end else begin
      if (in_tready) begin
        in_v_r <= in_tvalid;
      end
      if (fin_free) begin
        fin_v_r <= s0_go && in_last_r;
      end
      if (out_free) begin
        out_v_r <= fin_v_r;
      end
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    if (fin_free) begin
      fin_age_r <= res_age;
    end
    if (out_free) begin
      out_ms_r <= out_ms_nxt;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(32 - hcma_pkg::MS_W){1'b0}}, out_ms_r};

  `HCMA_ASSERT_NEXT(a_last_reaches_fin, s0_go && in_last_r, fin_v_r,
                    "last byte lost before result stage")
  `HCMA_ASSERT_NEXT(a_fin_holds, fin_v_r && !fin_free, fin_v_r && $stable(fin_age_r),
                    "held result changed")
  `HCMA_ASSERT_IMPL(a_out_range, out_tvalid, out_tdata[31:26] == 6'd0,
                    "result exceeds 26 bits")

endmodule
